FILE: sv/zbps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbps_pkg
// Shared constants, codes and helpers of the z-buffered point splatter.
// ----------------------------------------------------------------------------
package zbps_pkg;

  localparam int ROWS   = 32;
  localparam int COLS   = 64;
  localparam int DEPTH  = ROWS * COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MEM_W  = 36;

  localparam int DIV_W     = 64;
  localparam int DIV_CNT_W = 6;

  localparam logic ACT_PLOT = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [2:0] REG_X_SCALE      = 3'd0;
  localparam logic [2:0] REG_Y_SCALE      = 3'd1;
  localparam logic [2:0] REG_DEPTH_SCALE  = 3'd2;
  localparam logic [2:0] REG_DEPTH_OFFSET = 3'd3;
  localparam logic [2:0] REG_CENTRE_X     = 3'd4;
  localparam logic [2:0] REG_CENTRE_Y     = 3'd5;
  localparam logic [2:0] REG_CENTRE_Z     = 3'd6;

  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [7:0] RAMP [12] = '{
    8'h2e, 8'h2c, 8'h2d, 8'h7e, 8'h3a, 8'h3b,
    8'h3d, 8'h21, 8'h2a, 8'h23, 8'h24, 8'h40
  };

  function automatic logic [7:0] glyph_char(input logic [3:0] g);
    logic [7:0] c;
    c = CHAR_SPACE;
    if (g >= 4'd1 && g <= 4'd12) c = RAMP[g - 4'd1];
    return c;
  endfunction

  // saturating signed 32-bit add
  function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = 33'(a) + 33'(b);
    if (s > 33'sh0_7fff_ffff)       r = 32'sh7fff_ffff;
    else if (s < -33'sh0_8000_0000) r = 32'sh8000_0000;
    else                            r = s[31:0];
    return r;
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // ((p + 1.0) * n) / 2.0 truncated toward zero
  function automatic logic signed [55:0] proj_coord(input logic signed [41:0] p,
                                                    input int n);
    logic signed [55:0] t;
    logic signed [55:0] q;
    t = (56'(p) + 56'sd65536) * $signed(56'(n));
    if (t < 0) q = (t + 56'sd131071) >>> 17;
    else       q = t >>> 17;
    return q;
  endfunction

endpackage

FILE: sv/zbps_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbps_div
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module zbps_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [zbps_pkg::DIV_W-1:0] dividend,
  input  logic [zbps_pkg::DIV_W-1:0] divisor,
  output logic                       done,
  output logic [zbps_pkg::DIV_W-1:0] quotient
);

  logic                           run_r, run_nxt;
  logic                           done_r, done_nxt;
  logic [zbps_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [zbps_pkg::DIV_W-1:0]     quo_r, quo_nxt;
  logic [zbps_pkg::DIV_W-1:0]     rem_r, rem_nxt;
  logic [zbps_pkg::DIV_W-1:0]     dvs_r, dvs_nxt;
  logic [zbps_pkg::DIV_W:0]       trial;
  logic [zbps_pkg::DIV_W:0]       diff;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[zbps_pkg::DIV_W-1]};
    diff     = trial - {1'b0, dvs_r};
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (run_r) begin
      if (!diff[zbps_pkg::DIV_W]) begin
        rem_nxt = diff[zbps_pkg::DIV_W-1:0];
        quo_nxt = {quo_r[zbps_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[zbps_pkg::DIV_W-1:0];
        quo_nxt = {quo_r[zbps_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == '1) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: sv/zbuffer_point_splatter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbuffer_point_splatter_unit
// Perspective point splatter onto a z-buffered ASCII luminance canvas.
// ----------------------------------------------------------------------------
// Use: drive an item on the in_ ports and raise start; it is taken at an edge
// where busy is low. A plot item projects the point and may update one pixel;
// it gives no result. A read item gives one result: out_valid is high for one
// cycle with out_pixel_char, and that pixel is cleared.
// A read in range registers the stored pixel and answers from S_RCLR; a read
// off the canvas registers its result at acceptance. A plot that reaches the
// canvas keeps busy high through three passes of the shared radix-2 divider
// (x, y, inverse depth), multiplier steps and a read-modify-write of the depth
// memory. A plot dropped at acceptance (zero depth, non-positive luminance)
// costs nothing. Registers are written through cfg_we/cfg_index/cfg_wdata; the
// user must write them only while idle, which the block does not enforce;
// indexes beyond the list are ignored. Reset: rst_n low restores the
// registers, then busy stays high while the pixel memory is swept to blank.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module zbuffer_point_splatter_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_action,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic signed [31:0] in_normal_x,
  input  logic signed [31:0] in_normal_y,
  input  logic signed [31:0] in_normal_z,
  input  logic [4:0]         in_read_row,
  input  logic [5:0]         in_read_col,
  output logic               out_valid,
  output logic [7:0]         out_pixel_char,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  typedef enum logic [12:0] {
    S_CLR  = 13'b0000000000001,
    S_IDLE = 13'b0000000000010,
    S_RCLR = 13'b0000000000100,
    S_MULZ = 13'b0000000001000,
    S_PZ   = 13'b0000000010000,
    S_MULX = 13'b0000000100000,
    S_DIVX = 13'b0000001000000,
    S_MULY = 13'b0000010000000,
    S_DIVY = 13'b0000100000000,
    S_DIVZ = 13'b0001000000000,
    S_PRJ  = 13'b0010000000000,
    S_ADDR = 13'b0100000000000,
    S_CMP  = 13'b1000000000000
  } state_t;

  localparam int AW = zbps_pkg::ADDR_W;

  state_t state_r, state_nxt;

  logic signed [31:0] x_scale_r, y_scale_r, depth_scale_r, depth_offset_r;
  logic signed [31:0] centre_x_r, centre_y_r, centre_z_r;

  logic signed [31:0] cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic [3:0]         glyph_r, glyph_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic signed [49:0] pz_r, pz_nxt;
  logic signed [41:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [31:0] invz_r, invz_nxt;
  logic [AW-1:0]      row_r, row_nxt, col_r, col_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [AW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic               neg_r, neg_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_char_r, out_char_nxt;
  logic               div_start_r, div_start_nxt;

  logic [zbps_pkg::MEM_W-1:0] mem_r [zbps_pkg::DEPTH];
  logic [zbps_pkg::MEM_W-1:0] mem_q_r;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  logic [zbps_pkg::MEM_W-1:0] mem_wdata;

  logic [63:0]        div_dividend, div_divisor, div_q;
  logic               div_done;
  logic signed [31:0] acc_cx, acc_cy, acc_cz;
  logic signed [33:0] acc_lum;
  logic [63:0]        q_clamp;
  logic signed [55:0] qc, qr;
  logic               acc_ok;

  zbps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    if (state_r == S_DIVZ) begin
      div_dividend = 64'h1_0000_0000;
      div_divisor  = zbps_pkg::abs64(64'(cz_r));
    end else begin
      div_dividend = zbps_pkg::abs64(prod_r);
      div_divisor  = zbps_pkg::abs64(64'(pz_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_scale_r      <= 32'sd122291;
      y_scale_r      <= 32'sd244583;
      depth_scale_r  <= 32'sd65667;
      depth_offset_r <= -32'sd131203;
      centre_x_r     <= '0;
      centre_y_r     <= '0;
      centre_z_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        zbps_pkg::REG_X_SCALE:      x_scale_r      <= cfg_wdata;
        zbps_pkg::REG_Y_SCALE:      y_scale_r      <= cfg_wdata;
        zbps_pkg::REG_DEPTH_SCALE:  depth_scale_r  <= cfg_wdata;
        zbps_pkg::REG_DEPTH_OFFSET: depth_offset_r <= cfg_wdata;
        zbps_pkg::REG_CENTRE_X:     centre_x_r     <= cfg_wdata;
        zbps_pkg::REG_CENTRE_Y:     centre_y_r     <= cfg_wdata;
        zbps_pkg::REG_CENTRE_Z:     centre_z_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    acc_cx  = zbps_pkg::sat_add32(in_point_x, centre_x_r);
    acc_cy  = zbps_pkg::sat_add32(in_point_y, centre_y_r);
    acc_cz  = zbps_pkg::sat_add32(in_point_z, centre_z_r);
    acc_lum = -(34'(in_normal_y) + 34'(in_normal_z));
    acc_ok  = (32'(in_read_row) < zbps_pkg::ROWS) && (32'(in_read_col) < zbps_pkg::COLS);
    q_clamp = (div_q > 64'h100_0000_0000) ? 64'h100_0000_0000 : div_q;
    qc      = zbps_pkg::proj_coord(px_r, zbps_pkg::COLS);
    qr      = zbps_pkg::proj_coord(py_r, zbps_pkg::ROWS);
  end

  always_comb begin
    state_nxt     = state_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cz_nxt        = cz_r;
    glyph_nxt     = glyph_r;
    prod_nxt      = prod_r;
    pz_nxt        = pz_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    invz_nxt      = invz_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    addr_nxt      = addr_r;
    clr_cnt_nxt   = clr_cnt_r;
    neg_nxt       = neg_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    div_start_nxt = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = '0;
    mem_raddr     = addr_r;

    unique case (state_r)
      S_CLR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (32'(clr_cnt_r) == zbps_pkg::DEPTH - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (in_action == zbps_pkg::ACT_READ) begin
            if (acc_ok) begin
              addr_nxt  = AW'(AW'(in_read_row) * AW'(zbps_pkg::COLS) + AW'(in_read_col));
              mem_raddr = addr_nxt;
              state_nxt = S_RCLR;
            end else begin
              out_valid_nxt = 1'b1;
              out_char_nxt  = zbps_pkg::CHAR_SPACE;
            end
          end else begin
            cx_nxt = acc_cx;
            cy_nxt = acc_cy;
            cz_nxt = acc_cz;
            if ((acc_lum >>> 13) > 34'sd11) glyph_nxt = 4'd12;
            else                            glyph_nxt = acc_lum[16:13] + 4'd1;
            if (acc_cz != 0 && acc_lum > 0) state_nxt = S_MULZ;
          end
        end
      end
      S_RCLR: begin
        mem_we        = 1'b1;
        out_valid_nxt = 1'b1;
        out_char_nxt  = zbps_pkg::glyph_char(mem_q_r[35:32]);
        state_nxt     = S_IDLE;
      end
      S_MULZ: begin
        prod_nxt  = cz_r * depth_scale_r;
        state_nxt = S_PZ;
      end
      S_PZ: begin
        pz_nxt = 50'(prod_r >>> 16) + 50'(depth_offset_r);
        if (pz_nxt == 0) state_nxt = S_IDLE;
        else             state_nxt = S_MULX;
      end
      S_MULX: begin
        prod_nxt      = cx_r * x_scale_r;
        neg_nxt       = cx_r[31] ^ x_scale_r[31] ^ pz_r[49];
        div_start_nxt = 1'b1;
        state_nxt     = S_DIVX;
      end
      S_DIVX: begin
        if (div_done) begin
          px_nxt    = neg_r ? -42'(q_clamp) : 42'(q_clamp);
          state_nxt = S_MULY;
        end
      end
      S_MULY: begin
        prod_nxt      = cy_r * y_scale_r;
        neg_nxt       = cy_r[31] ^ y_scale_r[31] ^ pz_r[49];
        div_start_nxt = 1'b1;
        state_nxt     = S_DIVY;
      end
      S_DIVY: begin
        if (div_done) begin
          py_nxt        = neg_r ? -42'(q_clamp) : 42'(q_clamp);
          div_start_nxt = 1'b1;
          state_nxt     = S_DIVZ;
        end
      end
      S_DIVZ: begin
        if (div_done) begin
          if (cz_r[31]) begin
            invz_nxt = (div_q > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-div_q);
          end else begin
            invz_nxt = (div_q > 64'h7fff_ffff) ? 32'sh7fff_ffff : div_q[31:0];
          end
          state_nxt = S_PRJ;
        end
      end
      S_PRJ: begin
        row_nxt = AW'(qr);
        col_nxt = AW'(qc);
        if (qc >= 0 && qc < 56'(zbps_pkg::COLS) && qr >= 0 && qr < 56'(zbps_pkg::ROWS)) begin
          state_nxt = S_ADDR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ADDR: begin
        addr_nxt  = AW'(row_r * AW'(zbps_pkg::COLS) + col_r);
        mem_raddr = addr_nxt;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (invz_r > $signed(mem_q_r[31:0])) begin
          mem_we    = 1'b1;
          mem_wdata = {glyph_r, invz_r};
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_waddr] <= mem_wdata;
    mem_q_r <= mem_r[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      div_start_r <= div_start_nxt;
    end
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    cz_r       <= cz_nxt;
    glyph_r    <= glyph_nxt;
    prod_r     <= prod_nxt;
    pz_r       <= pz_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    invz_r     <= invz_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    addr_r     <= addr_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_pixel_char = out_char_r;

  a_clear_writes_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> (mem_we && mem_wdata == '0))
    else $error("clearing pass wrote a non-blank entry");

  a_div_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVX || state_r == S_DIVY || state_r == S_DIVZ))
    else $error("divider finished outside a divide step");

  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_RCLR ||
                        (start && !busy && in_action == zbps_pkg::ACT_READ)))
    else $error("result strobe without a read item");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the z-buffered point splatter.
// Plot and read items are driven through the command port; an in-bench model
// of the projection and the depth/glyph canvas predicts every read result.
// Directed rows come first, then random scenes of points with random reads and
// a centre sweep, under several register settings including the extremes.
// ----------------------------------------------------------------------------
module testbench;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_action = zbps_pkg::ACT_PLOT;
  logic signed [31:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic signed [31:0] in_normal_x = '0, in_normal_y = '0, in_normal_z = '0;
  logic [4:0] in_read_row = '0;
  logic [5:0] in_read_col = '0;
  logic out_valid;
  logic [7:0] out_pixel_char;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  zbuffer_point_splatter_unit DUT (.*);

  typedef struct {
    logic               action;
    logic signed [31:0] px, py, pz, nx, ny, nz;
    logic [4:0]         row;
    logic [5:0]         col;
  } point_item_t;

  typedef struct {
    point_item_t it;
    logic        fixed;   // expected char typed in
    logic [7:0]  ch;
  } stim_row_t;

  logic signed [31:0] cfg_shadow [7];
  logic [3:0]         canvas_glyph [zbps_pkg::DEPTH];
  logic signed [31:0] canvas_depth [zbps_pkg::DEPTH];
  logic [7:0]         char_queue [$];
  int errors = 0;
  int idle_cycles = 0;
  bit calm = 0;

  task automatic report(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic longint sat32(input longint v);
    return v > 64'sd2147483647 ? 64'sd2147483647 :
           (v < -64'sd2147483648 ? -64'sd2147483648 : v);
  endfunction

  function automatic longint clamp40(input longint v);
    longint lim = 64'sd1 <<< 40;
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  task automatic splat_point(input point_item_t t);
    longint cx, cy, cz, lum, pz, x, y, c, r, iz, idx, prod;
    int at;
    cx = sat32(longint'(t.px) + cfg_shadow[zbps_pkg::REG_CENTRE_X]);
    cy = sat32(longint'(t.py) + cfg_shadow[zbps_pkg::REG_CENTRE_Y]);
    cz = sat32(longint'(t.pz) + cfg_shadow[zbps_pkg::REG_CENTRE_Z]);
    lum = -(longint'(t.ny) + longint'(t.nz));
    if (cz == 0) return;
    prod = cz * longint'(cfg_shadow[zbps_pkg::REG_DEPTH_SCALE]);
    pz = (prod >>> 16) + cfg_shadow[zbps_pkg::REG_DEPTH_OFFSET];
    if (pz == 0) return;
    x = clamp40((cx * longint'(cfg_shadow[zbps_pkg::REG_X_SCALE])) / pz);
    y = clamp40((cy * longint'(cfg_shadow[zbps_pkg::REG_Y_SCALE])) / pz);
    c = ((x + 65536) * zbps_pkg::COLS) / 131072;
    r = ((y + 65536) * zbps_pkg::ROWS) / 131072;
    if (c < 0 || c >= zbps_pkg::COLS || r < 0 || r >= zbps_pkg::ROWS || lum <= 0) return;
    iz = sat32((64'sd1 <<< 32) / cz);
    at = int'(r) * zbps_pkg::COLS + int'(c);
    if (iz > longint'(canvas_depth[at])) begin
      idx = lum / 8192;
      if (idx > 11) idx = 11;
      canvas_depth[at] = iz[31:0];
      canvas_glyph[at] = 4'(idx + 1);
    end
  endtask

  function automatic logic [7:0] read_pixel(input logic [4:0] r, input logic [5:0] c);
    logic [3:0] g;
    int at;
    if (int'(r) >= zbps_pkg::ROWS || int'(c) >= zbps_pkg::COLS) return zbps_pkg::CHAR_SPACE;
    at = int'(r) * zbps_pkg::COLS + int'(c);
    g = canvas_glyph[at];
    canvas_glyph[at] = '0;
    canvas_depth[at] = '0;
    return (g >= 1 && g <= 12) ? zbps_pkg::RAMP[g - 1] : zbps_pkg::CHAR_SPACE;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_shadow[idx] = v;
  endtask

  task automatic drain;
    start <= 1'b0;
    while (char_queue.size() != 0) @(negedge clk);
    repeat (260) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  // item is accepted at the first rising edge with busy low
  task automatic send(input point_item_t t);
    if (!calm) while ($urandom_range(99) < 29) begin
      start <= 1'b0;
      @(negedge clk);
    end
    in_action <= t.action;
    in_point_x <= t.px; in_point_y <= t.py; in_point_z <= t.pz;
    in_normal_x <= t.nx; in_normal_y <= t.ny; in_normal_z <= t.nz;
    in_read_row <= t.row; in_read_col <= t.col;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (t.action == zbps_pkg::ACT_READ) char_queue.push_back(read_pixel(t.row, t.col));
    else splat_point(t);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (char_queue.size() == 0) report("result with nothing expected");
      else begin
        logic [7:0] e;
        e = char_queue.pop_front();
        if (out_pixel_char !== e)
          report($sformatf("pixel_char %h expected %h", out_pixel_char, e));
      end
    end
  end

  always @(posedge clk) begin
    if (start && !busy) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic point_item_t rand_item(input bit near);
    point_item_t t;
    t.action = ($urandom_range(99) < 30) ? zbps_pkg::ACT_READ : zbps_pkg::ACT_PLOT;
    if (near) begin
      t.px = $signed($urandom_range(0, 262144)) - 131072;
      t.py = $signed($urandom_range(0, 262144)) - 131072;
      t.pz = $signed($urandom_range(0, 262144)) - 131072;
      t.ny = -$signed($urandom_range(0, 120000)) + 10000;
      t.nz = -$signed($urandom_range(0, 40000));
    end else begin
      t.px = $urandom; t.py = $urandom; t.pz = $urandom;
      t.ny = $urandom; t.nz = $urandom;
    end
    t.nx = $urandom;
    t.row = 5'($urandom); t.col = 6'($urandom);
    return t;
  endfunction

  function automatic point_item_t mk(input logic a, input int x, y, z, ny, nz,
                                     input int r, c);
    point_item_t t;
    t.action = a; t.px = x; t.py = y; t.pz = z;
    t.nx = 32'h8000_0001; t.ny = ny; t.nz = nz; t.row = 5'(r); t.col = 6'(c);
    return t;
  endfunction

  stim_row_t directed [$];

  initial begin
    logic [31:0] extremes [4];
    point_item_t t;
    extremes = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    cfg_shadow = '{122291, 244583, 65667, -131203, 0, 0, 0};
    foreach (canvas_glyph[i]) begin
      canvas_glyph[i] = '0;
      canvas_depth[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);

    // blank canvas, corner reads, extremes, degenerate depth, saturation
    directed.push_back('{mk(zbps_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0), 1, zbps_pkg::CHAR_SPACE});
    directed.push_back('{mk(zbps_pkg::ACT_READ, 0, 0, 0, 0, 0, 31, 63), 1,
                         zbps_pkg::CHAR_SPACE});
    directed.push_back('{mk(zbps_pkg::ACT_PLOT, 0, 0, 0, -65536, 0, 0, 0), 0, 0});
    directed.push_back('{mk(zbps_pkg::ACT_PLOT, 0, 0, 65536, -200000, -200000, 0, 0), 0, 0});
    directed.push_back('{mk(zbps_pkg::ACT_PLOT, 0, 0, -65536, -8192, 0, 0, 0), 0, 0});
    directed.push_back('{mk(zbps_pkg::ACT_PLOT, 1000, 1000, 30000, -9000, 0, 0, 0), 0, 0});
    directed.push_back('{mk(zbps_pkg::ACT_PLOT, 0, 0, 65536, 0, 0, 0, 0), 0, 0});
    directed.push_back('{mk(zbps_pkg::ACT_PLOT, 'h7fffffff, 'h7fffffff, 'h7fffffff,
                            'h80000000, 'h80000000, 0, 0), 0, 0});
    directed.push_back('{mk(zbps_pkg::ACT_PLOT, 'h80000000, 'h80000000, 'h80000000,
                            'h7fffffff, 'h7fffffff, 0, 0), 0, 0});
    directed.push_back('{mk(zbps_pkg::ACT_PLOT, 'h80000000, 0, -1, -1, -1, 0, 0), 0, 0});
    for (int r = 14; r < 18; r++)
      for (int c = 30; c < 34; c++)
        directed.push_back('{mk(zbps_pkg::ACT_READ, 0, 0, 0, 0, 0, r, c), 0, 0});
    foreach (directed[i]) begin
      send(directed[i].it);
      if (directed[i].fixed && char_queue.size() != 0 &&
          char_queue[$] !== directed[i].ch)
        report("predicted char disagrees with table");
    end

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      if (phase == 1 || phase == 4) begin
        for (int k = 0; k < 7; k++) write_reg(k[2:0], extremes[$urandom_range(3)]);
      end else if (phase > 0) begin
        write_reg(zbps_pkg::REG_X_SCALE, $urandom_range(40000, 200000));
        write_reg(zbps_pkg::REG_Y_SCALE, $urandom_range(40000, 300000));
        write_reg(zbps_pkg::REG_DEPTH_SCALE, $urandom_range(30000, 90000));
        write_reg(zbps_pkg::REG_DEPTH_OFFSET, -$signed($urandom_range(0, 200000)));
        write_reg(zbps_pkg::REG_CENTRE_X, $signed($urandom_range(0, 20000)) - 10000);
        write_reg(zbps_pkg::REG_CENTRE_Y, $signed($urandom_range(0, 20000)) - 10000);
        write_reg(zbps_pkg::REG_CENTRE_Z, $signed($urandom_range(0, 20000)) - 10000);
      end
      calm = (phase == 2);
      for (int n = 0; n < 235; n++) begin
        t = rand_item($urandom_range(99) < 85);
        send(t);
      end
      // sweep reads of the centre region to harvest glyphs
      for (int r = 12; r < 20; r++) begin
        t = mk(zbps_pkg::ACT_READ, 0, 0, 0, 0, 0, r, $urandom_range(24, 40));
        send(t);
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (errors == 0 && char_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
